@@ hw/rtl/reva_pkg.sv @@
// Shared types, codes and reset constants for the rotary encoder value adjuster.
package reva_pkg;

   // Event codes carried on the request operation field
   localparam logic [1:0] OP_PULSE_EDGE = 2'd0;
   localparam logic [1:0] OP_DIR_EDGE   = 2'd1;
   localparam logic [1:0] OP_TIMER_TICK = 2'd2;
   localparam logic [1:0] OP_BUTTON     = 2'd3;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKOUT_TICKS  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_MAX      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_MAX     = 8'd3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned COUNT_W = 8;
   localparam int unsigned VALUE_W = 16;

   // Reset values
   localparam logic [COUNT_W-1:0] TICK_THRESHOLD_RST = 8'd3;
   localparam logic [COUNT_W-1:0] LOCKOUT_TICKS_RST  = 8'd4;
   localparam logic [VALUE_W-1:0] FIRST_MAX_RST      = 16'd100;
   localparam logic [VALUE_W-1:0] SECOND_MAX_RST     = 16'd200;
   localparam logic [VALUE_W-1:0] FIRST_VALUE_RST    = 16'd50;
   localparam logic [VALUE_W-1:0] SECOND_VALUE_RST   = 16'd100;

   typedef struct packed {
      logic [COUNT_W-1:0] tick_threshold;
      logic [COUNT_W-1:0] lockout_ticks;
      logic [VALUE_W-1:0] first_max;
      logic [VALUE_W-1:0] second_max;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_W-1:0] first_value;
      logic [VALUE_W-1:0] second_value;
      logic               page;
      logic               locked_out;
   } result_type;

endpackage

@@ hw/rtl/reva_core.sv @@
// Encoder decode, debounce lockout, page select and value stepping state.
module reva_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           operation,
   input  logic                 pulse_level,
   input  logic                 dir_level,
   input  reva_pkg::cfg_type    cfg,
   output reva_pkg::result_type result
);

   logic [reva_pkg::COUNT_W-1:0] up_ticks_ff, up_ticks_in;
   logic [reva_pkg::COUNT_W-1:0] down_ticks_ff, down_ticks_in;
   logic                         phase_ff, phase_in;
   logic                         lockout_ff, lockout_in;
   logic [reva_pkg::COUNT_W-1:0] lockout_count_ff, lockout_count_in;
   logic                         page_ff, page_in;
   logic [reva_pkg::VALUE_W-1:0] value_one_ff, value_one_in;
   logic [reva_pkg::VALUE_W-1:0] value_two_ff, value_two_in;

   logic                         is_dir;
   logic                         same;
   logic                         count_up;
   logic                         count_down;
   logic [reva_pkg::COUNT_W-1:0] up_inc;
   logic [reva_pkg::COUNT_W-1:0] down_inc;
   logic [reva_pkg::COUNT_W-1:0] lock_inc;
   logic                         step_up;
   logic                         step_down;
   logic [reva_pkg::VALUE_W-1:0] cur_value;
   logic [reva_pkg::VALUE_W-1:0] cur_ceil;
   logic [reva_pkg::VALUE_W:0]   value_plus;
   logic [reva_pkg::VALUE_W-1:0] stepped_value;

   // Decode the edge against the stored phase
   assign is_dir     = (operation == reva_pkg::OP_DIR_EDGE);
   assign same       = (pulse_level == dir_level);
   assign count_up   = (!is_dir && same && !phase_ff) || (is_dir && !same && phase_ff);
   assign count_down = (is_dir && same && !phase_ff) || (!is_dir && !same && phase_ff);
   assign up_inc     = up_ticks_ff + 1'b1;
   assign down_inc   = down_ticks_ff + 1'b1;
   assign lock_inc   = lockout_count_ff + 1'b1;
   assign step_up    = count_up && (up_inc >= cfg.tick_threshold);
   assign step_down  = count_down && (down_inc >= cfg.tick_threshold);

   // Saturating step of the value on the selected page
   assign cur_value  = page_ff ? value_two_ff : value_one_ff;
   assign cur_ceil   = page_ff ? cfg.second_max : cfg.first_max;
   assign value_plus = {1'b0, cur_value} + 1'b1;

   always_comb begin
      stepped_value = cur_value;
      if (step_up) begin
         if (value_plus > {1'b0, cur_ceil}) begin
            stepped_value = cur_ceil;
         end else begin
            stepped_value = value_plus[reva_pkg::VALUE_W-1:0];
         end
      end else if (step_down && (cur_value != '0)) begin
         stepped_value = cur_value - 1'b1;
      end
   end

   // Next state for the accepted event
   always_comb begin
      up_ticks_in      = up_ticks_ff;
      down_ticks_in    = down_ticks_ff;
      phase_in         = phase_ff;
      lockout_in       = lockout_ff;
      lockout_count_in = lockout_count_ff;
      page_in          = page_ff;
      value_one_in     = value_one_ff;
      value_two_in     = value_two_ff;
      unique case (operation) inside
         reva_pkg::OP_PULSE_EDGE, reva_pkg::OP_DIR_EDGE: begin
            if (!lockout_ff) begin
               // Clear the opposite counter, count this direction
               if (same ^ is_dir) begin
                  down_ticks_in = '0;
               end else begin
                  up_ticks_in = '0;
               end
               if (count_up) begin
                  up_ticks_in = step_up ? '0 : up_inc;
               end
               if (count_down) begin
                  down_ticks_in = step_down ? '0 : down_inc;
               end
               if (page_ff) begin
                  value_two_in = stepped_value;
               end else begin
                  value_one_in = stepped_value;
               end
               phase_in   = same;
               lockout_in = 1'b1;
            end
         end
         reva_pkg::OP_TIMER_TICK: begin
            if (lockout_ff) begin
               if (lock_inc >= cfg.lockout_ticks) begin
                  lockout_count_in = '0;
                  lockout_in       = 1'b0;
               end else begin
                  lockout_count_in = lock_inc;
               end
            end
         end
         default: begin
            page_in = !page_ff;
         end
      endcase
   end

   // Hold state between accepted transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         up_ticks_ff      <= '0;
         down_ticks_ff    <= '0;
         phase_ff         <= 1'b0;
         lockout_ff       <= 1'b0;
         lockout_count_ff <= '0;
         page_ff          <= 1'b0;
         value_one_ff     <= reva_pkg::FIRST_VALUE_RST;
         value_two_ff     <= reva_pkg::SECOND_VALUE_RST;
      end else if (accept) begin
         up_ticks_ff      <= up_ticks_in;
         down_ticks_ff    <= down_ticks_in;
         phase_ff         <= phase_in;
         lockout_ff       <= lockout_in;
         lockout_count_ff <= lockout_count_in;
         page_ff          <= page_in;
         value_one_ff     <= value_one_in;
         value_two_ff     <= value_two_in;
      end
   end

   // Result reflects the state after the event
   assign result.first_value  = value_one_in;
   assign result.second_value = value_two_in;
   assign result.page         = page_in;
   assign result.locked_out   = lockout_in;

   // A running lockout count exists only inside a lockout
   assert property (@(posedge clock) disable iff (reset)
      (lockout_count_ff != '0) |-> lockout_ff)
      else $error("lockout count running without lockout");

   // Counting one direction always clears the other
   assert property (@(posedge clock) disable iff (reset)
      !((up_ticks_ff != '0) && (down_ticks_ff != '0)))
      else $error("up and down tick counters both nonzero");

   // An edge taken outside lockout starts a lockout
   assert property (@(posedge clock) disable iff (reset)
      (accept && !lockout_ff && ((operation == reva_pkg::OP_PULSE_EDGE) ||
       (operation == reva_pkg::OP_DIR_EDGE))) |=> lockout_ff)
      else $error("accepted edge did not start lockout");

endmodule

@@ hw/rtl/rotary_encoder_value_adjuster.sv @@
// Top level of the rotary encoder value adjuster: csr registers and result buffer.
//
// Usage: each req transaction carries one event (pulse edge, direction edge,
// timer tick or button press) with the current pin levels. Every event gives
// exactly one rsp transaction holding both values, the page and the lockout
// flag as they stand after the event. Registers are written over the csr
// channel (index 0 tick threshold, 1 lockout ticks, 2 first max, 3 second max);
// csr_ready is always high and other indexes are dropped. Write them only while
// no response is outstanding.
// An accepted request's response is registered into the head or the skid entry.
// Throughput: one event per cycle while req_ready is high; the whole update is one
// pass of compare and add logic from the state registers into a two-entry response buffer.
// Stalls: the buffer holds a response plus one more; req_ready drops only when
// both entries are occupied, and rises again as soon as rsp takes one.
// Reset: synchronous, active high; clears the buffer, restores the register
// defaults (3, 4, 100, 200), values 50 and 100, page 0, no lockout.
module rotary_encoder_value_adjuster (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_operation,
   input  logic                               req_pulse_level,
   input  logic                               req_dir_level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [reva_pkg::VALUE_W-1:0]       rsp_first_value,
   output logic [reva_pkg::VALUE_W-1:0]       rsp_second_value,
   output logic                               rsp_page,
   output logic                               rsp_locked_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [reva_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [reva_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   reva_pkg::cfg_type    cfg_ff;
   reva_pkg::result_type result;
   reva_pkg::result_type head_ff;
   reva_pkg::result_type skid_ff;
   logic                 head_valid_ff;
   logic                 skid_valid_ff;
   logic                 push;
   logic                 pop;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = head_valid_ff && rsp_ready;

   // Decode csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_threshold <= reva_pkg::TICK_THRESHOLD_RST;
         cfg_ff.lockout_ticks  <= reva_pkg::LOCKOUT_TICKS_RST;
         cfg_ff.first_max      <= reva_pkg::FIRST_MAX_RST;
         cfg_ff.second_max     <= reva_pkg::SECOND_MAX_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            reva_pkg::CSR_TICK_THRESHOLD:
               cfg_ff.tick_threshold <= csr_wdata[reva_pkg::COUNT_W-1:0];
            reva_pkg::CSR_LOCKOUT_TICKS:
               cfg_ff.lockout_ticks <= csr_wdata[reva_pkg::COUNT_W-1:0];
            reva_pkg::CSR_FIRST_MAX:
               cfg_ff.first_max <= csr_wdata[reva_pkg::VALUE_W-1:0];
            reva_pkg::CSR_SECOND_MAX:
               cfg_ff.second_max <= csr_wdata[reva_pkg::VALUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   reva_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (push),
      .operation   (req_operation),
      .pulse_level (req_pulse_level),
      .dir_level   (req_dir_level),
      .cfg         (cfg_ff),
      .result      (result)
   );

   // Two-entry response buffer: advance skid into head on pop
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (skid_valid_ff) begin
               head_valid_ff <= 1'b1;
               skid_valid_ff <= push;
            end else begin
               head_valid_ff <= push;
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (head_valid_ff) begin
               skid_valid_ff <= 1'b1;
            end else begin
               head_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
            if (push) begin
               skid_ff <= result;
            end
         end else if (push) begin
            head_ff <= result;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_ff <= result;
         end else begin
            head_ff <= result;
         end
      end
   end

   assign rsp_valid        = head_valid_ff;
   assign rsp_first_value  = head_ff.first_value;
   assign rsp_second_value = head_ff.second_value;
   assign rsp_page         = head_ff.page;
   assign rsp_locked_out   = head_ff.locked_out;

   // The skid entry is only ever behind an occupied head
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry occupied with empty head");

   // Every accepted request leaves a response pending
   assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid)
      else $error("accepted request produced no response");

   // A full buffer that is not drained stays full and keeps req blocked
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> !req_ready)
      else $error("full buffer lost an entry without a pop");

endmodule
